// File: design/rotation_matrix_to_euler_assert.svh
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_assert.svh
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_EULER_ASSERT_SVH
`define ROTATION_MATRIX_TO_EULER_ASSERT_SVH

// same-cycle implication
`define RME_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define RME_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// File: design/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// types, constants and helper functions of the euler angle pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rme_pkg;

  localparam int XW = 28;   // cordic x, y width
  localparam int ZW = 35;   // cordic angle width, Q30 radians
  localparam int TABLE_LEN = 24;
  localparam int SQ_STEPS = 16;

  localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [ZW-1:0] ANGLE_LIMIT = 35'sd25736;

  localparam logic [2:0] OP_XYZ = 3'd0;
  localparam logic [2:0] OP_XZY = 3'd1;
  localparam logic [2:0] OP_YXZ = 3'd2;
  localparam logic [2:0] OP_YZX = 3'd3;
  localparam logic [2:0] OP_ZXY = 3'd4;
  localparam logic [2:0] OP_ZYX = 3'd5;

  typedef logic [8:0][15:0] mat_t;

  typedef struct packed {
    logic [2:0] op;
    mat_t       m;
  } item_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

  typedef struct packed {
    logic lock;
    logic bneg;
    logic cneg;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 35'sd843314857;
      5'd1:  v = 35'sd497837829;
      5'd2:  v = 35'sd263043837;
      5'd3:  v = 35'sd133525159;
      5'd4:  v = 35'sd67021687;
      5'd5:  v = 35'sd33543516;
      5'd6:  v = 35'sd16775851;
      5'd7:  v = 35'sd8388437;
      5'd8:  v = 35'sd4194283;
      5'd9:  v = 35'sd2097149;
      5'd10: v = 35'sd1048576;
      5'd11: v = 35'sd524288;
      5'd12: v = 35'sd262144;
      5'd13: v = 35'sd131072;
      5'd14: v = 35'sd65536;
      5'd15: v = 35'sd32768;
      5'd16: v = 35'sd16384;
      5'd17: v = 35'sd8192;
      5'd18: v = 35'sd4096;
      5'd19: v = 35'sd2048;
      5'd20: v = 35'sd1024;
      5'd21: v = 35'sd512;
      5'd22: v = 35'sd256;
      5'd23: v = 35'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [16:0] ext(input logic [15:0] v);
    return {v[15], v};
  endfunction

  function automatic logic signed [16:0] neg(input logic [15:0] v);
    return -{v[15], v};
  endfunction

  // fold the left half plane onto the right one and scale by 256
  function automatic lane_t lane_init(input logic signed [16:0] y,
                                      input logic signed [16:0] x);
    lane_t l;
    logic signed [XW-1:0] xe;
    logic signed [XW-1:0] ye;
    xe = XW'(x);
    ye = XW'(y);
    l.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      l.z = y[16] ? -PI_Q30 : PI_Q30;
      xe = -xe;
      ye = -ye;
    end else begin
      l.z = '0;
    end
    l.x = xe <<< 8;
    l.y = ye <<< 8;
    return l;
  endfunction

  function automatic lane_t cordic_step(input lane_t l, input logic [4:0] i);
    lane_t o;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    dx = l.x >>> i;
    dy = l.y >>> i;
    o = l;
    if (!l.y[XW-1]) begin
      o.x = l.x + dy;
      o.y = l.y - dx;
      o.z = l.z + atan_q30(i);
    end else begin
      o.x = l.x - dy;
      o.y = l.y + dx;
      o.z = l.z - atan_q30(i);
    end
    return o;
  endfunction

  function automatic logic signed [15:0] round_angle(input lane_t l);
    logic signed [ZW-1:0] t;
    logic signed [ZW-1:0] q;
    t = l.z + (ZW'(1) <<< 16);
    q = t >>> 17;
    if (l.zero) q = '0;
    else if (q > ANGLE_LIMIT) q = ANGLE_LIMIT;
    else if (q < -ANGLE_LIMIT) q = -ANGLE_LIMIT;
    return q[15:0];
  endfunction

endpackage

`default_nettype wire

// File: design/rotation_matrix_to_euler.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler
// rotation matrix (Q1.14) to euler angles (Q2.13) for six rotation orders
// ----------------------------------------------------------------------------
// channel  signals                              direction
// in       in_valid in_ready operation r11..r33 into the block
// out      out_valid out_ready angle_* gimbal_lock out of the block
// cfg      cfg_valid cfg_ready cfg_data         into the block, lock_threshold
//
// one matrix per cycle unless the output stalls; cordic steps capped at 24;
// stages: input register, squares, 16 root stages, select, cordic, rounding
// the root and the cordic are one register stage per bit / micro-rotation
// reset clears valid bits and sets lock_threshold to 16
// a stalled output freezes the pipe; an empty input register still takes one
// more transfer, so nothing is lost or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_euler
  import rme_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  operation,
  input  wire logic [15:0] r11,
  input  wire logic [15:0] r12,
  input  wire logic [15:0] r13,
  input  wire logic [15:0] r21,
  input  wire logic [15:0] r22,
  input  wire logic [15:0] r23,
  input  wire logic [15:0] r31,
  input  wire logic [15:0] r32,
  input  wire logic [15:0] r33,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      angle_first,
  output logic [15:0]      angle_second,
  output logic [15:0]      angle_third,
  output logic             gimbal_lock,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [14:0] cfg_data
);

  localparam int NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  logic [14:0] lock_threshold;
  logic        en;
  logic        load0;
  logic        v0;
  item_t       s0;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign load0     = !v0 || en;
  assign in_ready  = load0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_threshold <= 15'd16;
    end else if (cfg_valid) begin
      lock_threshold <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (load0) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load0) begin
      s0.op <= operation;
      s0.m  <= {r33, r32, r31, r23, r22, r21, r13, r12, r11};
    end
  end

  // squares of the two cos(beta) entries
  logic        [15:0] p;
  logic        [15:0] q;
  logic signed [31:0] pp_full;
  logic signed [31:0] qq_full;
  logic               v1;
  item_t              s1;
  logic        [30:0] pp;
  logic        [30:0] qq;

  always_comb begin
    case (s0.op)
      OP_XYZ:  begin p = s0.m[0]; q = s0.m[1]; end
      OP_XZY:  begin p = s0.m[0]; q = s0.m[2]; end
      OP_YXZ:  begin p = s0.m[3]; q = s0.m[4]; end
      OP_YZX:  begin p = s0.m[0]; q = s0.m[6]; end
      OP_ZXY:  begin p = s0.m[6]; q = s0.m[8]; end
      OP_ZYX:  begin p = s0.m[7]; q = s0.m[8]; end
      default: begin p = '0; q = '0; end
    endcase
    pp_full = $signed(p) * $signed(p);
    qq_full = $signed(q) * $signed(q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s0;
      pp <= pp_full[30:0];
      qq <= qq_full[30:0];
    end
  end

  // integer square root, one result bit per stage
  logic        sq_v [1:SQ_STEPS];
  item_t       sq_i [1:SQ_STEPS];
  logic [31:0] sq_n [1:SQ_STEPS];
  logic [31:0] sq_r [1:SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [31:0] BIT = 32'(1) << (30 - 2 * j);
    logic        vin;
    item_t       iin;
    logic [31:0] nin;
    logic [31:0] rin;
    logic [31:0] trial;

    if (j == 0) begin : g_first
      assign vin = v1;
      assign iin = s1;
      assign nin = {1'b0, pp} + {1'b0, qq};
      assign rin = '0;
    end else begin : g_rest
      assign vin = sq_v[j];
      assign iin = sq_i[j];
      assign nin = sq_n[j];
      assign rin = sq_r[j];
    end

    assign trial = rin + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else if (en) begin
        sq_v[j+1] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_i[j+1] <= iin;
        if (nin >= trial) begin
          sq_n[j+1] <= nin - trial;
          sq_r[j+1] <= (rin >> 1) + BIT;
        end else begin
          sq_n[j+1] <= nin;
          sq_r[j+1] <= rin >> 1;
        end
      end
    end
  end

  // lock decision and arctangent argument select
  item_t              it;
  logic        [15:0] cb;
  logic               op_ok;
  logic               lock;
  side_t              side_sel;
  logic signed [16:0] ya, xa, yb, xb, yc, xc;
  logic signed [16:0] sb;
  logic               sel_v;
  lane_t              sel_l [3];
  side_t              sel_s;

  assign it    = sq_i[SQ_STEPS];
  assign cb    = sq_r[SQ_STEPS][15:0];
  assign op_ok = (it.op <= OP_ZYX);
  assign lock  = op_ok && !(cb > {1'b0, lock_threshold});

  always_comb begin
    ya = '0; xa = '0; yb = '0; xb = '0; yc = '0; xc = '0;
    sb = '0;
    side_sel = '0;
    side_sel.lock = lock;
    case (it.op)
      OP_XYZ:  sb = ext(it.m[2]);
      OP_XZY:  sb = neg(it.m[1]);
      OP_YXZ:  sb = neg(it.m[5]);
      OP_YZX:  sb = ext(it.m[3]);
      OP_ZXY:  sb = ext(it.m[7]);
      OP_ZYX:  sb = neg(it.m[6]);
      default: sb = '0;
    endcase
    if (op_ok && !lock) begin
      yb = sb;
      xb = {1'b0, cb};
      case (it.op)
        OP_XYZ:  begin ya = neg(it.m[5]); xa = ext(it.m[8]);
                       yc = neg(it.m[1]); xc = ext(it.m[0]); end
        OP_XZY:  begin ya = ext(it.m[7]); xa = ext(it.m[4]);
                       yc = ext(it.m[2]); xc = ext(it.m[0]); end
        OP_YXZ:  begin ya = ext(it.m[2]); xa = ext(it.m[8]);
                       yc = ext(it.m[3]); xc = ext(it.m[4]); end
        OP_YZX:  begin ya = neg(it.m[6]); xa = ext(it.m[0]);
                       yc = neg(it.m[5]); xc = ext(it.m[4]); end
        OP_ZXY:  begin ya = neg(it.m[1]); xa = ext(it.m[4]);
                       yc = neg(it.m[6]); xc = ext(it.m[8]); end
        default: begin ya = ext(it.m[3]); xa = ext(it.m[0]);
                       yc = ext(it.m[7]); xc = ext(it.m[8]); end
      endcase
    end else if (lock) begin
      case (it.op)
        OP_XYZ: begin
          side_sel.bneg = it.m[2][15];
          side_sel.cneg = it.m[2][15];
          yc = ext(it.m[3]);
          xc = it.m[2][15] ? ext(it.m[4]) : neg(it.m[4]);
        end
        OP_XZY: begin
          side_sel.bneg = !it.m[1][15];
          yc = ext(it.m[5]); xc = ext(it.m[8]);
        end
        OP_YXZ: begin
          side_sel.bneg = !it.m[5][15];
          yc = ext(it.m[6]); xc = ext(it.m[7]);
        end
        OP_YZX: begin
          side_sel.bneg = it.m[3][15];
          side_sel.cneg = it.m[3][15];
          yc = ext(it.m[7]); xc = ext(it.m[8]);
        end
        OP_ZXY: begin
          side_sel.bneg = it.m[7][15];
          yc = ext(it.m[3]); xc = ext(it.m[4]);
        end
        default: begin
          side_sel.bneg = !it.m[6][15];
          yc = ext(it.m[1]); xc = ext(it.m[4]);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_v <= 1'b0;
    end else if (en) begin
      sel_v <= sq_v[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_l[0] <= lane_init(ya, xa);
      sel_l[1] <= lane_init(yb, xb);
      sel_l[2] <= lane_init(yc, xc);
      sel_s    <= side_sel;
    end
  end

  // cordic vectoring, one micro-rotation per stage on three lanes
  logic  cv [1:NSTEP];
  lane_t cl [1:NSTEP][3];
  side_t cs [1:NSTEP];

  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    logic  vin;
    lane_t lin [3];
    side_t sin_q;

    if (i == 0) begin : g_first
      assign vin   = sel_v;
      assign lin   = sel_l;
      assign sin_q = sel_s;
    end else begin : g_rest
      assign vin   = cv[i];
      assign lin   = cl[i];
      assign sin_q = cs[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          cl[i+1][k] <= cordic_step(lin[k], 5'(i));
        end
        cs[i+1] <= sin_q;
      end
    end
  end

  // rounding to Q2.13 and output register
  logic signed [15:0] fa, fb, fc;
  side_t              fs;

  always_comb begin
    fs = cs[NSTEP];
    fa = round_angle(cl[NSTEP][0]);
    fb = round_angle(cl[NSTEP][1]);
    fc = round_angle(cl[NSTEP][2]);
    if (fs.lock) begin
      fa = '0;
      fb = fs.bneg ? -HALF_PI_Q13 : HALF_PI_Q13;
    end
    if (fs.cneg) fc = -fc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cv[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_first  <= fa;
      angle_second <= fb;
      angle_third  <= fc;
      gimbal_lock  <= fs.lock;
    end
  end

endmodule

`default_nettype wire

// File: design/rme_checker.sv
// ----------------------------------------------------------------------------
// rme_checker
// port-level checks on the euler angle block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "rotation_matrix_to_euler_assert.svh"

module rme_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [2:0]  operation,
  input wire logic [15:0] r11,
  input wire logic [15:0] r12,
  input wire logic [15:0] r13,
  input wire logic [15:0] r21,
  input wire logic [15:0] r22,
  input wire logic [15:0] r23,
  input wire logic [15:0] r31,
  input wire logic [15:0] r32,
  input wire logic [15:0] r33,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] angle_first,
  input wire logic [15:0] angle_second,
  input wire logic [15:0] angle_third,
  input wire logic        gimbal_lock,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [14:0] cfg_data
);

  logic [48:0] out_word;
  logic        lock_ok;
  logic        out_wait;

  assign out_word = {angle_first, angle_second, angle_third, gimbal_lock};
  assign out_wait = out_valid && !out_ready;
  // alpha is zero and beta is exactly plus or minus pi/2 in Q2.13
  assign lock_ok  = (angle_first == 16'd0) &&
                    (angle_second == 16'd12868 || angle_second == 16'hCDBC);

  // a result that waits keeps its valid
  `RME_ASSERT_NEXT(a_out_hold, clk, rst, out_wait, out_valid)

  // a result that waits keeps its payload
  `RME_ASSERT_NEXT(a_out_stable, clk, rst, out_wait, $stable(out_word))

  // locked result: alpha zero, beta at plus or minus pi/2
  `RME_ASSERT_NOW(a_lock_angles, clk, rst, out_valid && gimbal_lock, lock_ok)

  // with no result waiting the input is always open
  `RME_ASSERT_NOW(a_in_free, clk, rst, !out_valid, in_ready)

endmodule

bind rotation_matrix_to_euler rme_checker u_rme_checker (.*);

`default_nettype wire
